// File: hdl/bafq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafq_pkg
// Shared types and constants for the block allocator with free queue.
// ----------------------------------------------------------------------------
package bafq_pkg;

   localparam int FREE_QUEUE_DEPTH_DEF = 64;
   localparam int ADDRESS_BITS_DEF     = 32;

   localparam int FIELD_ADDR_BITS = 32;
   localparam int SIZE_BITS       = 20;
   localparam int CSR_DATA_BITS   = 32;
   localparam int CSR_INDEX_BITS  = 2;

   localparam int REQ_TDATA_BITS = 56;
   localparam int RSP_TDATA_BITS = 40;

   localparam logic [SIZE_BITS-1:0] BLOCK_SIZE_RESET = 20'd4096;

   typedef enum logic [1:0] {
      KIND_ALIGNED   = 2'd0,
      KIND_UNALIGNED = 2'd1,
      KIND_FREE      = 2'd2,
      KIND_RESERVED  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_OOM   = 2'd1,
      STATUS_MODE  = 2'd2,
      STATUS_FULL  = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_HEAP_BASE      = 2'd0,
      CSR_HEAP_LIMIT     = 2'd1,
      CSR_BLOCK_SIZE     = 2'd2,
      CSR_UNALIGNED_MODE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctl_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_sts_type;

endpackage

// File: hdl/bafq_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafq_queue
// FIFO of freed addresses in a single-port-write memory, with the entry at
// the head kept in a read register so it is ready when a pop is decided.
// ----------------------------------------------------------------------------
module bafq_queue
   import bafq_pkg::*;
#(
   parameter int DEPTH  = FREE_QUEUE_DEPTH_DEF,
   parameter int ADDR_W = ADDRESS_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  queue_ctl_type     ctl,
   input  logic [ADDR_W-1:0] push_data,
   output queue_sts_type     sts,
   output logic [ADDR_W-1:0] head_data
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [ADDR_W-1:0] mem [DEPTH];

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [PTR_W-1:0]  tail_ff, tail_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] rd_data_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (ctl.pop) begin
         head_in  = (head_ff == LAST_PTR) ? '0 : head_ff + 1'b1;
         count_in = count_ff - 1'b1;
      end
      if (ctl.push) begin
         tail_in  = (tail_ff == LAST_PTR) ? '0 : tail_ff + 1'b1;
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // write at tail, read the next head; a write into an empty queue bypasses
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[tail_ff] <= push_data;
      end
      if (ctl.push && (tail_ff == head_in)) begin
         rd_data_ff <= push_data;
      end else begin
         rd_data_ff <= mem[head_in];
      end
   end

   assign sts.empty = (count_ff == '0);
   assign sts.full  = (count_ff == FULL_CNT);
   assign head_data = rd_data_ff;

endmodule

// File: hdl/bafq_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bafq_engine
// Configuration registers, bump pointer and the per-request decision:
// queue reuse, bump carve with bound check, mode check and free enqueue.
// ----------------------------------------------------------------------------
module bafq_engine
   import bafq_pkg::*;
#(
   parameter int ADDR_W = ADDRESS_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write,
   input  csr_index_type              csr_index,
   input  logic [CSR_DATA_BITS-1:0]   csr_data,
   input  logic                       exec,
   input  kind_type                   kind,
   input  logic [SIZE_BITS-1:0]       request_size,
   input  logic [FIELD_ADDR_BITS-1:0] freed_address,
   input  queue_sts_type              queue_sts,
   input  logic [ADDR_W-1:0]          queue_head_data,
   output queue_ctl_type              queue_ctl,
   output logic [ADDR_W-1:0]          queue_push_data,
   output logic [FIELD_ADDR_BITS-1:0] granted_address,
   output status_type                 status
);

   localparam int CMP_W = (ADDR_W > SIZE_BITS) ? ADDR_W : SIZE_BITS;

   logic [ADDR_W-1:0]          bump_ff, bump_in;
   logic [FIELD_ADDR_BITS-1:0] heap_limit_ff;
   logic [SIZE_BITS-1:0]       block_size_ff;
   logic                       unaligned_ff;

   logic [ADDR_W-1:0]    limit;
   logic [ADDR_W-1:0]    room;
   logic [SIZE_BITS-1:0] carve_size;
   logic                 fits;
   logic                 do_bump;
   logic                 do_pop;
   logic                 do_push;
   logic [ADDR_W-1:0]    addr;

   assign limit      = ADDR_W'(heap_limit_ff);
   assign room       = limit - bump_ff;
   assign carve_size = (kind == KIND_UNALIGNED) ? request_size : block_size_ff;
   assign fits       = (bump_ff <= limit) && (CMP_W'(carve_size) <= CMP_W'(room));

   always_comb begin
      status  = STATUS_OK;
      addr    = '0;
      do_bump = 1'b0;
      do_pop  = 1'b0;
      do_push = 1'b0;
      unique case (kind)
         KIND_ALIGNED: begin
            if (unaligned_ff) begin
               status = STATUS_MODE;
            end else if (!queue_sts.empty) begin
               addr   = queue_head_data;
               do_pop = 1'b1;
            end else if (fits) begin
               addr    = bump_ff;
               do_bump = 1'b1;
            end else begin
               status = STATUS_OOM;
            end
         end
         KIND_UNALIGNED: begin
            if (!unaligned_ff) begin
               status = STATUS_MODE;
            end else if (fits) begin
               addr    = bump_ff;
               do_bump = 1'b1;
            end else begin
               status = STATUS_OOM;
            end
         end
         KIND_FREE: begin
            if (queue_sts.full) begin
               status = STATUS_FULL;
            end else begin
               do_push = 1'b1;
            end
         end
         default: begin
            status = STATUS_MODE;
         end
      endcase
   end

   assign queue_ctl.pop    = exec && do_pop;
   assign queue_ctl.push   = exec && do_push;
   assign queue_push_data  = ADDR_W'(freed_address);
   assign granted_address  = FIELD_ADDR_BITS'(addr);

   always_comb begin
      bump_in = bump_ff;
      if (csr_write && (csr_index == CSR_HEAP_BASE)) begin
         bump_in = ADDR_W'(csr_data);
      end else if (exec && do_bump) begin
         bump_in = bump_ff + ADDR_W'(carve_size);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff       <= '0;
         heap_limit_ff <= '0;
         block_size_ff <= BLOCK_SIZE_RESET;
         unaligned_ff  <= 1'b0;
      end else begin
         bump_ff <= bump_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_HEAP_BASE: begin
               end
               CSR_HEAP_LIMIT: begin
                  heap_limit_ff <= csr_data;
               end
               CSR_BLOCK_SIZE: begin
                  block_size_ff <= csr_data[SIZE_BITS-1:0];
               end
               CSR_UNALIGNED_MODE: begin
                  unaligned_ff <= csr_data[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

// File: hdl/block_allocator_with_free_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_allocator_with_free_queue
// Heap allocator: aligned blocks reused from a FIFO free queue or carved at
// a bump pointer, unaligned carves, and frees into the queue.
//
// channel   direction  transfer when          contents
// req_      in         req_tvalid&req_tready  tuser kind, tdata size/address
// rsp_      out        rsp_tvalid&rsp_tready  tdata granted address, status
// csr_      in         csr_valid&csr_ready    register index, write data
//
// one request per cycle while the response is not stalled; a request is held
// in the input register, then the result register; the queue head is held in a
// read register so it is ready when a pop is decided
// synchronous reset clears pointers, counts, valid flags and configuration registers; no clearing pass
// a stalled response holds the result register and backs up the input side
// ----------------------------------------------------------------------------
module block_allocator_with_free_queue
   import bafq_pkg::*;
#(
   parameter int FREE_QUEUE_DEPTH = FREE_QUEUE_DEPTH_DEF,
   parameter int ADDRESS_BITS     = ADDRESS_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_TDATA_BITS-1:0] req_tdata,   // request_size, freed_address, zero pad
   input  logic [1:0]                req_tuser,   // kind
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // granted_address, status, zero pad
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data
);

   logic                       req_valid_ff, req_valid_in;
   logic [1:0]                 req_kind_ff;
   logic [SIZE_BITS-1:0]       req_size_ff;
   logic [FIELD_ADDR_BITS-1:0] req_faddr_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [FIELD_ADDR_BITS-1:0] rsp_addr_ff;
   status_type                 rsp_status_ff;

   logic                       exec;
   logic                       req_take;
   queue_ctl_type              queue_ctl;
   queue_sts_type              queue_sts;
   logic [ADDRESS_BITS-1:0]    queue_push_data;
   logic [ADDRESS_BITS-1:0]    queue_head_data;
   logic [FIELD_ADDR_BITS-1:0] granted_address;
   status_type                 status;

   assign exec       = req_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !req_valid_ff || exec;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign req_valid_in = req_tready ? req_tvalid : req_valid_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_kind_ff  <= req_tuser;
         req_size_ff  <= req_tdata[SIZE_BITS-1:0];
         req_faddr_ff <= req_tdata[SIZE_BITS +: FIELD_ADDR_BITS];
      end
      if (exec) begin
         rsp_addr_ff   <= granted_address;
         rsp_status_ff <= status;
      end
   end

   bafq_queue #(
      .DEPTH  (FREE_QUEUE_DEPTH),
      .ADDR_W (ADDRESS_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctl       (queue_ctl),
      .push_data (queue_push_data),
      .sts       (queue_sts),
      .head_data (queue_head_data)
   );

   bafq_engine #(
      .ADDR_W (ADDRESS_BITS)
   ) u_engine (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index_type'(csr_index)),
      .csr_data        (csr_data),
      .exec            (exec),
      .kind            (kind_type'(req_kind_ff)),
      .request_size    (req_size_ff),
      .freed_address   (req_faddr_ff),
      .queue_sts       (queue_sts),
      .queue_head_data (queue_head_data),
      .queue_ctl       (queue_ctl),
      .queue_push_data (queue_push_data),
      .granted_address (granted_address),
      .status          (status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_status_ff, rsp_addr_ff};

endmodule

// File: sim/tb_block_allocator_with_free_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_block_allocator_with_free_queue
// Self-checking bench for the heap allocator. It runs a short directed pass
// over empty, tight, wrapped and full-range heap windows, then a series of
// randomly configured phases with reuse, carve and flood traffic. A tracker
// keeps its own copy of the bump pointer and free queue, predicts each
// response and checks it in order. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_block_allocator_with_free_queue;
   import bafq_pkg::*;

   typedef struct {
      logic [FIELD_ADDR_BITS-1:0] addr;
      status_type                 status;
   } grant_type;

   class heap_tracker_type;
      logic [31:0] heap_base;
      logic [31:0] heap_limit;
      logic [19:0] blk_size;
      logic        unaligned_en;
      logic [31:0] bump;
      logic [31:0] free_fifo[$];
      grant_type   expected_grants[$];
      int          fail_count;
      int          checked;
      int          reuse_count;
      int          tally[4];

      function new();
         heap_base    = '0;
         heap_limit   = '0;
         blk_size     = BLOCK_SIZE_RESET;
         unaligned_en = 1'b0;
         bump         = '0;
         fail_count   = 0;
         checked      = 0;
         reuse_count  = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] val);
         case (idx)
            CSR_HEAP_BASE: begin
               heap_base = val;
               bump      = val;
            end
            CSR_HEAP_LIMIT:     heap_limit   = val;
            CSR_BLOCK_SIZE:     blk_size     = val[19:0];
            CSR_UNALIGNED_MODE: unaligned_en = val[0];
            default: ;
         endcase
      endfunction

      function bit carve(logic [31:0] n, output logic [31:0] at);
         at = '0;
         if (bump > heap_limit || n > heap_limit - bump) return 1'b0;
         at   = bump;
         bump = bump + n;
         return 1'b1;
      endfunction

      function void note_request(kind_type k, logic [19:0] size, logic [31:0] faddr);
         grant_type g;
         g.addr   = '0;
         g.status = STATUS_OK;
         case (k)
            KIND_ALIGNED: begin
               if (unaligned_en) begin
                  g.status = STATUS_MODE;
               end else if (free_fifo.size() > 0) begin
                  g.addr = free_fifo.pop_front();
                  reuse_count++;
               end else if (!carve({12'd0, blk_size}, g.addr)) begin
                  g.status = STATUS_OOM;
               end
            end
            KIND_UNALIGNED: begin
               if (!unaligned_en) begin
                  g.status = STATUS_MODE;
               end else if (!carve({12'd0, size}, g.addr)) begin
                  g.status = STATUS_OOM;
               end
            end
            KIND_FREE: begin
               if (free_fifo.size() >= FREE_QUEUE_DEPTH_DEF) g.status = STATUS_FULL;
               else free_fifo.push_back(faddr);
            end
            default: g.status = STATUS_MODE;
         endcase
         expected_grants.push_back(g);
      endfunction

      function void check_grant(logic [31:0] addr, logic [1:0] st);
         grant_type want;
         if (expected_grants.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("unexpected response transfer: addr=%h status=%0d", addr, st);
            return;
         end
         want = expected_grants.pop_front();
         checked++;
         tally[want.status]++;
         if (addr !== want.addr || st !== want.status) begin
            fail_count++;
            if (fail_count <= 10)
               $display("mismatch on response %0d: expected addr=%h status=%s,",
                        checked, want.addr, want.status.name(),
                        " got addr=%h status=%0d", addr, st);
         end
      endfunction

      function int outstanding();
         return expected_grants.size();
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;   // request_size, freed_address, zero pad
   logic [1:0]                req_tuser;   // kind
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;   // granted_address, status, zero pad
   logic                      csr_valid;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_data;

   heap_tracker_type sb;
   int               req_style;
   int               rsp_style;
   int               sent_count;
   int               phase_count;
   logic [31:0]      recent_grants[$];

   block_allocator_with_free_queue dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic int draw_gap(int style);
      case (style)
         0: return 0;
         1: return $urandom_range(0, 11);
         default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
      endcase
   endfunction

   task automatic send_request(kind_type k, logic [19:0] size, logic [31:0] faddr);
      int gap;
      gap = draw_gap(req_style);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tuser  <= k;
      req_tdata  <= {4'd0, faddr, size};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sb.note_request(k, size, faddr);
      sent_count++;
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_heap(bit [3:0] which, logic [31:0] base, logic [31:0] limit,
                               logic [31:0] bsize_word, logic mode);
      logic [31:0] val;
      for (int i = 0; i < 4; i++) begin
         if (which[i]) begin
            case (csr_index_type'(i))
               CSR_HEAP_BASE:  val = base;
               CSR_HEAP_LIMIT: val = limit;
               CSR_BLOCK_SIZE: val = bsize_word;
               default:        val = {31'd0, mode};
            endcase
            csr_index <= csr_index_type'(i);
            csr_data  <= val;
            csr_valid <= 1'b1;
            do @(posedge clock); while (!csr_ready);
            sb.write_reg(csr_index_type'(i), val);
         end
      end
      csr_valid <= 1'b0;
   endtask

   task automatic random_phase(int count);
      logic [31:0] base;
      logic [31:0] span;
      logic [19:0] bs;
      logic        mode;
      bit          flood;
      int          r;
      kind_type    k;
      logic [19:0] size;
      logic [31:0] faddr;
      case ($urandom_range(0, 4))
         0:       base = 32'd0;
         1:       base = 32'hFFFF_FFFF - $urandom_range(0, 1 << 22);
         default: base = $urandom;
      endcase
      case ($urandom_range(0, 4))
         0:       bs = 20'd1;
         1:       bs = 20'hFFFFF;
         4:       bs = 20'($urandom_range(1, 20'hFFFFF));
         default: bs = 20'($urandom_range(1, 4096));
      endcase
      case ($urandom_range(0, 4))
         0:       span = $urandom_range(0, 3 * 32'(bs));
         1:       span = $urandom;
         default: span = 32'(bs) * $urandom_range(4, 200);
      endcase
      mode      = 1'($urandom_range(0, 1));
      flood     = ($urandom_range(0, 5) == 0);
      req_style = $urandom_range(0, 2);
      rsp_style = $urandom_range(0, 2);
      program_heap(4'hF, base,
                   ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF : base + span,
                   {12'($urandom), bs}, mode);
      phase_count++;
      for (int i = 0; i < count; i++) begin
         r     = $urandom_range(0, 99);
         size  = 20'($urandom);
         faddr = $urandom;
         if (r < 8) begin
            if ($urandom_range(0, 2) == 0) k = KIND_RESERVED;
            else k = mode ? KIND_ALIGNED : KIND_UNALIGNED;
         end else if (r < (flood ? 75 : 35)) begin
            k = KIND_FREE;
            if (recent_grants.size() > 0 && $urandom_range(0, 1))
               faddr = recent_grants[$urandom_range(0, recent_grants.size() - 1)];
         end else if (mode) begin
            k = KIND_UNALIGNED;
            case ($urandom_range(0, 9))
               0:       size = 20'd0;
               1, 2:    size = 20'($urandom_range(0, 20'hFFFFF));
               default: size = 20'($urandom_range(1, 4095));
            endcase
         end else begin
            k = KIND_ALIGNED;
         end
         send_request(k, size, faddr);
      end
      wait_idle();
   endtask

   initial begin : rsp_side
      int          gap;
      logic [31:0] addr;
      logic [1:0]  st;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_style);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         addr = rsp_tdata[31:0];
         st   = rsp_tdata[33:32];
         sb.check_grant(addr, st);
         if (st == STATUS_OK && addr != '0) begin
            recent_grants.push_back(addr);
            if (recent_grants.size() > 32) void'(recent_grants.pop_front());
         end
      end
   end

   initial begin
      int random_items;
      int n;
      sb           = new();
      sent_count   = 0;
      phase_count  = 0;
      random_items = 0;
      req_style    = 1;
      rsp_style    = 1;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_ALIGNED;
      rsp_tready <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_HEAP_BASE;
      csr_data   <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window is empty
      send_request(KIND_ALIGNED, 20'd0, 32'd0);
      send_request(KIND_UNALIGNED, 20'hFFFFF, 32'hFFFF_FFFF);
      send_request(KIND_RESERVED, 20'd0, 32'd0);
      send_request(KIND_FREE, 20'hFFFFF, 32'hFFFF_FFFF);
      send_request(KIND_ALIGNED, 20'd0, 32'd0);
      wait_idle();
      // two blocks fit exactly, third runs out
      program_heap(4'b0111, 32'h0000_1000, 32'h0000_3000, 32'h0000_1000, 1'b0);
      repeat (3) send_request(KIND_ALIGNED, 20'd0, 32'd0);
      wait_idle();
      // pointer sits at the limit
      program_heap(4'b1000, '0, '0, '0, 1'b1);
      send_request(KIND_UNALIGNED, 20'd0, 32'd0);
      send_request(KIND_UNALIGNED, 20'd1, 32'd0);
      send_request(KIND_ALIGNED, 20'd0, 32'd0);
      send_request(KIND_FREE, 20'd0, 32'd0);
      wait_idle();
      // base above limit
      program_heap(4'b0011, 32'hFFFF_FFFF, 32'h0, '0, 1'b1);
      send_request(KIND_UNALIGNED, 20'd0, 32'd0);
      wait_idle();
      // zero block size, queued entry reused first
      program_heap(4'b1111, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0);
      repeat (3) send_request(KIND_ALIGNED, 20'hFFFFF, 32'hFFFF_FFFF);
      wait_idle();
      program_heap(4'b1000, '0, '0, '0, 1'b1);
      repeat (2) send_request(KIND_UNALIGNED, 20'hFFFFF, 32'd0);
      wait_idle();
      // top of the address space
      program_heap(4'b0011, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1'b1);
      send_request(KIND_UNALIGNED, 20'd0, 32'd0);
      send_request(KIND_UNALIGNED, 20'd1, 32'd0);
      wait_idle();

      while (random_items < 700) begin
         n = $urandom_range(30, 90);
         random_phase(n);
         random_items += n;
      end
      wait_idle();
      repeat (10) @(posedge clock);

      $display("ran %0d requests over %0d random heap settings: %0d ok, %0d out of memory,",
               sent_count, phase_count, sb.tally[STATUS_OK], sb.tally[STATUS_OOM]);
      $display("%0d wrong mode, %0d queue full, %0d blocks reused from the free queue",
               sb.tally[STATUS_MODE], sb.tally[STATUS_FULL], sb.reuse_count);
      if (sb.fail_count == 0 && sb.outstanding() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
